[src/lmsort_pkg.sv]
// ---------------------------------------------------------------------------
// lmsort_pkg: shared types for the quicksort sorter
// Datapath operation codes and the status group reported to the controller.
// ---------------------------------------------------------------------------
package lmsort_pkg;

  localparam int unsigned DATA_W = 32;

  // One operation per cycle, issued by the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_POPTAKE,
    OP_PIVOT,
    OP_SCAN,
    OP_SWAP1,
    OP_SWAP2,
    OP_FIN1,
    OP_FIN2,
    OP_PUSH2,
    OP_EMIT,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic cnt_lt2;    // fewer than two items stored
    logic sp_zero;    // range stack empty
    logic range_ok;   // popped range has lo < hi
    logic scan_swap;  // scanned item below pivot and mark != scan
    logic scan_last;  // scan + 1 == hi
    logic emit_last;  // item being emitted is the final one
  } dp_status_t;

endpackage

[src/lmsort_dp.sv]
// ---------------------------------------------------------------------------
// lmsort_dp: sorter datapath
// Element store, range stack, partition indexes and the result register.
// ---------------------------------------------------------------------------
module lmsort_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lmsort_pkg::dp_op_t                  op,
  input  logic signed [lmsort_pkg::DATA_W-1:0] in_value,
  output lmsort_pkg::dp_status_t              status,
  output logic                                out_valid,
  output logic signed [lmsort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                out_last_out,
  output logic                                out_overflow
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = 2 * IW;
  localparam int unsigned DW = lmsort_pkg::DATA_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // memories
  logic [DW-1:0] elem_mem [DEPTH];
  logic [SW-1:0] stack_mem [DEPTH];

  logic          we, re, swe, sre;
  logic [IW-1:0] waddr, raddr, swaddr, sraddr;
  logic [DW-1:0] wdata;
  logic [SW-1:0] swdata;
  logic [DW-1:0] rdata_r;
  logic [SW-1:0] srdata_r;

  // control registers
  logic [CW-1:0] cnt_r, cnt_nxt, sp_r, sp_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IW-1:0] mark_r, mark_nxt, scan_r, scan_nxt, k_r, k_nxt;
  logic [DW-1:0] piv_r, piv_nxt, dval_r, dval_nxt;
  logic          out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;

  logic [IW-1:0] mark_inc, mark_dec, scan_inc, k_inc;
  logic [CW-1:0] cnt_m1, sp_dec;
  logic          less, room, push_lo_ok, push_hi_ok;

  assign mark_inc = mark_r + IW'(1);
  assign mark_dec = mark_r - IW'(1);
  assign scan_inc = scan_r + IW'(1);
  assign k_inc    = k_r + IW'(1);
  assign cnt_m1   = cnt_r - CW'(1);
  assign sp_dec   = sp_r - CW'(1);
  assign less     = $signed(rdata_r) < $signed(piv_r);
  assign room     = sp_r < DEPTH_C;
  assign push_lo_ok = (mark_r > lo_r) && (mark_dec > lo_r);
  assign push_hi_ok = ((IW+1)'(mark_r) + (IW+1)'(1)) < (IW+1)'(hi_r);

  assign status.cnt_lt2   = cnt_r < CW'(2);
  assign status.sp_zero   = sp_r == '0;
  assign status.range_ok  = srdata_r[SW-1:IW] < srdata_r[IW-1:0];
  assign status.scan_swap = less && (mark_r != scan_r);
  assign status.scan_last = scan_inc == hi_r;
  assign status.emit_last = (CW'(k_r) + CW'(1)) == cnt_r;

  always_comb begin
    we = 1'b0; waddr = cnt_r[IW-1:0]; wdata = in_value;
    re = 1'b0; raddr = k_r;
    swe = 1'b0; swaddr = sp_r[IW-1:0]; swdata = '0;
    sre = 1'b0; sraddr = sp_dec[IW-1:0];
    cnt_nxt = cnt_r; sp_nxt = sp_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mark_nxt = mark_r; scan_nxt = scan_r;
    k_nxt = k_r; piv_nxt = piv_r; dval_nxt = dval_r;
    out_valid_nxt = 1'b0; out_last_nxt = out_last_r; out_ovf_nxt = out_ovf_r;
    case (op)
      lmsort_pkg::OP_LOAD: begin
        if (cnt_r < DEPTH_C) begin
          we      = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      lmsort_pkg::OP_INIT: begin
        k_nxt = '0;
        if (!status.cnt_lt2) begin
          swe    = 1'b1;
          swaddr = '0;
          swdata = {IW'(0), cnt_m1[IW-1:0]};
          sp_nxt = CW'(1);
        end else begin
          sp_nxt = '0;
        end
      end
      lmsort_pkg::OP_POP: begin
        sre    = 1'b1;
        sp_nxt = sp_dec;
      end
      lmsort_pkg::OP_POPTAKE: begin
        lo_nxt = srdata_r[SW-1:IW];
        hi_nxt = srdata_r[IW-1:0];
        re     = 1'b1;
        raddr  = srdata_r[IW-1:0];
      end
      lmsort_pkg::OP_PIVOT: begin
        piv_nxt  = rdata_r;
        mark_nxt = lo_r;
        scan_nxt = lo_r;
        re       = 1'b1;
        raddr    = lo_r;
      end
      lmsort_pkg::OP_SCAN: begin
        dval_nxt = rdata_r;
        re       = 1'b1;
        if (status.scan_swap) begin
          raddr = mark_r;
        end else begin
          if (less) mark_nxt = mark_inc;
          scan_nxt = scan_inc;
          // on the last scan step, fetch the final pivot slot instead
          if (status.scan_last) raddr = less ? mark_inc : mark_r;
          else raddr = scan_inc;
        end
      end
      lmsort_pkg::OP_SWAP1: begin
        we    = 1'b1;
        waddr = scan_r;
        wdata = rdata_r;
      end
      lmsort_pkg::OP_SWAP2: begin
        we       = 1'b1;
        waddr    = mark_r;
        wdata    = dval_r;
        mark_nxt = mark_inc;
        scan_nxt = scan_inc;
        re       = 1'b1;
        raddr    = status.scan_last ? mark_inc : scan_inc;
      end
      lmsort_pkg::OP_FIN1: begin
        we    = 1'b1;
        waddr = hi_r;
        wdata = rdata_r;
      end
      lmsort_pkg::OP_FIN2: begin
        we    = 1'b1;
        waddr = mark_r;
        wdata = piv_r;
        if (push_lo_ok && room) begin
          swe    = 1'b1;
          swdata = {lo_r, mark_dec};
          sp_nxt = sp_r + CW'(1);
        end
      end
      lmsort_pkg::OP_PUSH2: begin
        if (push_hi_ok && room) begin
          swe    = 1'b1;
          swdata = {mark_inc, hi_r};
          sp_nxt = sp_r + CW'(1);
        end
      end
      lmsort_pkg::OP_EMIT: begin
        re            = 1'b1;
        raddr         = k_r;
        k_nxt         = k_inc;
        out_valid_nxt = 1'b1;
        out_last_nxt  = status.emit_last;
        out_ovf_nxt   = ovf_r;
      end
      lmsort_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
        sp_nxt  = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mark_r     <= mark_nxt;
    scan_r     <= scan_nxt;
    k_r        <= k_nxt;
    piv_r      <= piv_nxt;
    dval_r     <= dval_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) elem_mem[waddr] <= wdata;
    if (re) rdata_r <= elem_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (swe) stack_mem[swaddr] <= swdata;
    if (sre) srdata_r <= stack_mem[sraddr];
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = rdata_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

[src/lmsort_ctrl.sv]
// ---------------------------------------------------------------------------
// lmsort_ctrl: sorter controller
// Sequences load, partition passes over the range stack, and emission.
// ---------------------------------------------------------------------------
module lmsort_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_last_item,
  input  lmsort_pkg::dp_status_t status,
  output lmsort_pkg::dp_op_t     op,
  output logic                   busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_POP, S_POPWAIT, S_PIVOT, S_SCAN, S_SWAP1, S_SWAP2,
    S_FIN1, S_FIN2, S_PUSH2, S_EMIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    op        = lmsort_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op = lmsort_pkg::OP_LOAD;
          if (in_last_item) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        op        = lmsort_pkg::OP_INIT;
        state_nxt = status.cnt_lt2 ? S_EMIT : S_POP;
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_nxt = S_EMIT;
        end else begin
          op        = lmsort_pkg::OP_POP;
          state_nxt = S_POPWAIT;
        end
      end
      S_POPWAIT: begin
        op        = lmsort_pkg::OP_POPTAKE;
        state_nxt = status.range_ok ? S_PIVOT : S_POP;
      end
      S_PIVOT: begin
        op        = lmsort_pkg::OP_PIVOT;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        op = lmsort_pkg::OP_SCAN;
        if (status.scan_swap) state_nxt = S_SWAP1;
        else if (status.scan_last) state_nxt = S_FIN1;
      end
      S_SWAP1: begin
        op        = lmsort_pkg::OP_SWAP1;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        op        = lmsort_pkg::OP_SWAP2;
        state_nxt = status.scan_last ? S_FIN1 : S_SCAN;
      end
      S_FIN1: begin
        op        = lmsort_pkg::OP_FIN1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        op        = lmsort_pkg::OP_FIN2;
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        op        = lmsort_pkg::OP_PUSH2;
        state_nxt = S_POP;
      end
      S_EMIT: begin
        op = lmsort_pkg::OP_EMIT;
        if (status.emit_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        op        = lmsort_pkg::OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

[src/quicksort_lomuto_sorter.sv]
// ---------------------------------------------------------------------------
// quicksort_lomuto_sorter: in-place quicksort over a stored item set
// Collects signed items, sorts them ascending with Lomuto partitioning and
// an explicit range stack, then streams them out with a final-item mark.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  input    | start & !busy        | in_value (s32), in_last_item
//  result   | out_valid, 1 cycle   | out_sorted_value (s32), out_last_out,
//           |                      | out_overflow
//
//  Loading takes one cycle per item; busy stays low until the last item.
//  Sort: each popped range takes pop, pivot fetch and set-up steps, a scan
//  step per item plus swap writes per exchange, then pivot placement and
//  subrange pushes, as the element store's single read port requires.
//  Emission is one item per cycle, then a clear step for the next set.
//  rst_n is synchronous; no clearing pass, store and stack are read only
//  where written. Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module quicksort_lomuto_sorter #(
  parameter int unsigned DEPTH = 64  // capacity, 2..64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [lmsort_pkg::DATA_W-1:0] in_value,
  input  logic                                 in_last_item,
  // result channel
  output logic                                 out_valid,
  output logic signed [lmsort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                 out_last_out,
  output logic                                 out_overflow
);

  lmsort_pkg::dp_op_t     op;
  lmsort_pkg::dp_status_t status;

  // sequencer: one datapath operation per cycle
  lmsort_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_item (in_last_item),
    .status       (status),
    .op           (op),
    .busy         (busy)
  );

  // store, stack, partition indexes and output register
  lmsort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_value         (in_value),
    .status           (status),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule

[src/lmsort_chk.sv]
// ---------------------------------------------------------------------------
// lmsort_chk: port-level checks for the sorter
// Watches the top level's handshake and result strobe over time.
// ---------------------------------------------------------------------------
module lmsort_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_item,
  input logic out_valid,
  input logic out_last_out
);

  // results appear only while the block is busy
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside busy");

  // busy stays low after an ordinary item is absorbed
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_item) |=> !busy)
    else $error("busy after a non-final item");

  // the final item starts the sort
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_item) |=> busy)
    else $error("final item did not start the sort");

  // nothing follows the item marked last
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid)
    else $error("result after final item");

endmodule

bind quicksort_lomuto_sorter lmsort_chk u_lmsort_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last_item (in_last_item),
  .out_valid    (out_valid),
  .out_last_out (out_last_out)
);

[test/tb_quicksort_lomuto_sorter.sv]
// ---------------------------------------------------------------------------
// tb_quicksort_lomuto_sorter: self-checking bench for the quicksort sorter
// Loads item sets of random size and content, some past the store capacity,
// keeps a shadow store that is sorted by the same Lomuto quicksort, and checks
// every emitted item (value, final mark, overflow flag) in order.
// ---------------------------------------------------------------------------
module tb_quicksort_lomuto_sorter;

  localparam int unsigned DATA_W      = lmsort_pkg::DATA_W;
  localparam int unsigned SET_CAP     = 64;         // store depth of the DUT
  localparam int          CYCLE_LIMIT = 1_000_000;  // hard stop for a hung run
  localparam int          LOAD_TARGET = 420;        // random items to load
  localparam int          DRAIN_WAIT  = 40;         // quiet cycles at the end

  // value shapes for a generated set
  typedef enum int {
    SHAPE_RANDOM,   // any 32-bit pattern
    SHAPE_DUPS,     // few distinct values, many repeats
    SHAPE_EXTREME,  // corners of the signed range
    SHAPE_RISING,   // already sorted
    SHAPE_FALLING   // reverse sorted, the costly case for a last-item pivot
  } set_shape_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } load_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic in_last_item = 1'b0;
  logic busy;
  logic out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic out_last_out;
  logic out_overflow;

  load_item_t   pending[$];     // items waiting to be loaded
  sorted_item_t sorted_due[$];  // emitted items still expected, oldest first

  // shadow copy of the block's state
  logic signed [DATA_W-1:0] shadow_store [0:SET_CAP-1];
  logic [11:0]              shadow_ranges [0:63];  // lo in 11:6, hi in 5:0
  int unsigned              shadow_count = 0;
  int unsigned              shadow_sp = 0;
  logic                     shadow_dropped = 1'b0;

  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int calm_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  quicksort_lomuto_sorter #(.DEPTH(SET_CAP)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  // -------------------------------------------------------------------------
  // Shadow quicksort: last element of a range is the pivot, ranges kept on an
  // explicit stack. Equal values leave the same order the partition leaves.
  // -------------------------------------------------------------------------
  function automatic void push_range(int unsigned lo, int unsigned hi);
    if (lo >= hi || shadow_sp >= 64) return;
    shadow_ranges[shadow_sp] = {lo[5:0], hi[5:0]};
    shadow_sp++;
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = shadow_store[a];
    shadow_store[a] = shadow_store[b];
    shadow_store[b] = t;
  endfunction

  function automatic int unsigned partition_range(int unsigned lo, int unsigned hi);
    logic signed [DATA_W-1:0] pivot;
    int unsigned mark;
    pivot = shadow_store[hi];
    mark = lo;
    for (int unsigned s = lo; s < hi; s++) begin
      if (shadow_store[s] < pivot) begin  // signed compare
        swap_slots(mark, s);
        mark++;
      end
    end
    swap_slots(mark, hi);
    return mark;
  endfunction

  function automatic void sort_shadow_set();
    logic [11:0] entry;
    int unsigned lo, hi, p;
    shadow_sp = 0;
    if (shadow_count < 2) return;
    push_range(0, shadow_count - 1);
    while (shadow_sp > 0) begin
      shadow_sp--;
      entry = shadow_ranges[shadow_sp];
      lo = 32'(entry[11:6]);
      hi = 32'(entry[5:0]);
      if (lo >= hi) continue;
      p = partition_range(lo, hi);
      if (p > lo) push_range(lo, p - 1);
      push_range(p + 1, hi);
    end
  endfunction

  // Called once per accepted item: store it (or drop it when full) and, on
  // the final item of a set, queue the whole sorted set as expected output.
  function automatic void absorb_item(load_item_t it);
    sorted_item_t r;
    if (shadow_count < SET_CAP) begin
      shadow_store[shadow_count] = it.value;
      shadow_count++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!it.last) return;
    sort_shadow_set();
    for (int unsigned k = 0; k < shadow_count; k++) begin
      r.value = shadow_store[k];
      r.last  = (k + 1 == shadow_count);
      r.ovf   = shadow_dropped;
      sorted_due.push_back(r);
    end
    shadow_count = 0;
    shadow_sp = 0;
    shadow_dropped = 1'b0;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus building
  // -------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] shape_value(set_shape_t shape, int k,
                                                           int len);
    logic signed [DATA_W-1:0] corner [5];
    corner = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1};
    case (shape)
      SHAPE_RANDOM:  return $urandom;
      SHAPE_DUPS:    return $signed($urandom_range(0, 6)) - 3;
      SHAPE_EXTREME: return corner[$urandom_range(0, 4)];
      SHAPE_RISING:  return k * 1000 - 20000;
      default:       return (len - k) * 997 - 9000;
    endcase
  endfunction

  // Queue one set; the last queued item always carries the final mark.
  function automatic int add_set(int len, set_shape_t shape);
    load_item_t it;
    for (int k = 0; k < len; k++) begin
      it.value = shape_value(shape, k, len);
      it.last  = (k == len - 1);
      pending.push_back(it);
    end
    return len;
  endfunction

  function automatic void add_fixed(logic signed [DATA_W-1:0] v, logic fin);
    load_item_t it;
    it.value = v;
    it.last  = fin;
    pending.push_back(it);
  endfunction

  // Source idling: mostly back to back or short, a few long gaps, and now and
  // then a calm stretch with no gaps at all.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 70) return $urandom_range(0, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: an item is taken at an edge where start is high and busy is low.
  // Once raised, start stays high while busy (the sort phase), so the next
  // set can sit waiting on the port until the block frees up.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    logic took;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        absorb_item(pending[0]);
        void'(pending.pop_front());
        gap_left = pick_gap();
      end
      if (took || !start) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (pending.size() != 0) begin
          start        <= 1'b1;
          in_value     <= pending[0].value;
          in_last_item <= pending[0].last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: results cannot be held off, so each strobe is checked as it comes.
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("MISMATCH cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sorted_item_t want;
    if (rst_n && out_valid) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("unexpected item, value", out_sorted_value, '0);
      end else begin
        want = sorted_due.pop_front();
        if (out_sorted_value !== want.value)
          report_mismatch("sorted_value", out_sorted_value, want.value);
        if (out_last_out !== want.last)
          report_mismatch("last_out", DATA_W'(out_last_out), DATA_W'(want.last));
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", DATA_W'(out_overflow), DATA_W'(want.ovf));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_quicksort_lomuto_sorter: errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: build every set up front, release reset, wait for drain.
  // -------------------------------------------------------------------------
  initial begin
    int loaded;
    int len;
    int r;
    set_shape_t shape;

    // directed sets: a lone item, the two corners, all corners mixed,
    // all-equal values, an already sorted run
    add_fixed(32'sh8000_0000, 1'b1);
    add_fixed(32'sh7fff_ffff, 1'b0);
    add_fixed(32'sh8000_0000, 1'b1);
    add_fixed(32'sh0, 1'b0);
    add_fixed(-32'sd1, 1'b0);
    add_fixed(32'sd1, 1'b0);
    add_fixed(32'sh7fff_ffff, 1'b0);
    add_fixed(32'sh8000_0000, 1'b0);
    add_fixed(32'sh7fff_ffff, 1'b0);
    add_fixed(32'sh8000_0000, 1'b0);
    add_fixed(32'sh0, 1'b1);
    for (int k = 0; k < 5; k++) add_fixed(32'sd7, k == 4);
    for (int k = 0; k < 4; k++) add_fixed(k + 1, k == 3);

    // random sets; a full store, a final item dropped on a full store and a
    // longer overrun are always in the mix
    loaded = 0;
    loaded += add_set(SET_CAP, SHAPE_FALLING);
    loaded += add_set(SET_CAP + 1, SHAPE_RANDOM);
    loaded += add_set(SET_CAP + $urandom_range(2, 6), SHAPE_DUPS);
    while (loaded < LOAD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60)      len = $urandom_range(1, 12);
      else if (r < 85) len = $urandom_range(13, 40);
      else if (r < 95) len = $urandom_range(41, SET_CAP);
      else             len = $urandom_range(SET_CAP + 1, SET_CAP + 6);
      r = $urandom_range(0, 99);
      if (r < 55)      shape = SHAPE_RANDOM;
      else if (r < 75) shape = SHAPE_DUPS;
      else if (r < 87) shape = SHAPE_EXTREME;
      else if (r < 94) shape = SHAPE_RISING;
      else             shape = SHAPE_FALLING;
      loaded += add_set(len, shape);
    end

    // hold the synchronous reset, then release it
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // every item loaded, then every sorted item seen, then a quiet tail to
    // catch anything emitted past the end of a set
    while (pending.size() != 0 || start) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("tb_quicksort_lomuto_sorter: clean");
    end else begin
      $display("tb_quicksort_lomuto_sorter: errors");
    end
    $finish;
  end

endmodule
